### rtl/ffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = AW + 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_LOST     = 2'd2
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } region_t;

endpackage

`default_nettype wire

### rtl/first_fit_free_list_allocator.sv
// An allocate on an empty table goes straight to the response state; a free on an empty table
// passes through FDEC first. With regions held, the scan and the entry moves together cover the
// table once. The region memory has a single read port and a single write port.
// One request at a time; the next is taken the cycle after the result is registered, and a
// new request is taken while a result waits.
// Reset (synchronous, active low) clears the entry count, peak, free total and lost counters;
// the region memory itself is not cleared; entries beyond the count may be read but are never used.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_free_list_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_block_addr,
  input  wire logic [31:0] in_block_size,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_granted_addr,
  output logic [1:0]       out_status,
  output logic [31:0]      out_free_total,
  output logic [12:0]      out_entry_count,
  output logic [12:0]      out_peak_entries,
  output logic [31:0]      out_lost_count,
  output logic [31:0]      out_lost_bytes
);

  localparam int CW = ffa_pkg::CW;
  localparam int AW = ffa_pkg::AW;

  // The sequencer walks the sorted table: SCAN reads one entry per cycle, FDEC decides how a
  // freed block joins its neighbors, SHDN and SHUP move entries to close or open a slot.
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FDEC, S_SHDN, S_SHUP, S_WINS, S_RESP
  } state_t;

  state_t           state_r;
  logic             req_r;
  logic [31:0]      addr_r;
  logic [31:0]      size_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    peak_r;
  logic [31:0]      sum_r;
  logic [31:0]      lostc_r;
  logic [31:0]      lostb_r;
  logic [CW-1:0]    chk_r;
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    pos_r;
  logic [CW-1:0]    lim_r;
  logic             have_prev_r;
  logic             next_vld_r;
  ffa_pkg::region_t prev_r;
  ffa_pkg::region_t next_r;
  logic [31:0]      grant_r;
  ffa_pkg::status_t status_r;
  logic             out_valid_r;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  ffa_pkg::region_t mem_wdata;
  logic [AW-1:0]    mem_raddr;
  ffa_pkg::region_t mem_q;

  logic prev_adj, next_adj, fits, last_chk;
  logic [31:0] merged_len;

  ffa_ram #(
    .WIDTH($bits(ffa_pkg::region_t)),
    .DEPTH(ffa_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_q)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  assign fits     = (mem_q.len >= size_r);
  assign last_chk = ((chk_r + 1'b1) == cnt_r);
  assign prev_adj = have_prev_r && ((prev_r.start + prev_r.len) == addr_r);
  assign next_adj = next_vld_r && ((addr_r + size_r) == next_r.start);
  assign merged_len = prev_r.len + size_r + (next_adj ? next_r.len : 32'd0);

  // Read address: the scan runs one entry ahead; shifts read the entry that moves next.
  always_comb begin
    mem_raddr = '0;
    unique case (state_r)
      S_IDLE: mem_raddr = '0;
      S_SCAN: mem_raddr = AW'(chk_r + 1'b1);
      S_FDEC: mem_raddr = (prev_adj && next_adj) ? AW'(pos_r + 1'b1) : AW'(cnt_r - 1'b1);
      S_SHDN: mem_raddr = AW'(idx_r + 1'b1);
      S_SHUP: mem_raddr = AW'(idx_r - 1'b1);
      S_WINS: mem_raddr = '0;
      S_RESP: mem_raddr = '0;
      default: mem_raddr = '0;
    endcase
  end

  // Write port: carving an allocation, merging, moving entries, placing a new region.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    unique case (state_r)
      S_SCAN: begin
        if (req_r == ffa_pkg::REQ_ALLOC && fits && mem_q.len != size_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(chk_r);
          mem_wdata = '{start: mem_q.start + size_r, len: mem_q.len - size_r};
        end
      end
      S_FDEC: begin
        if (prev_adj) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_r - 1'b1);
          mem_wdata = '{start: prev_r.start, len: merged_len};
        end else if (next_adj) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_r);
          mem_wdata = '{start: addr_r, len: next_r.len + size_r};
        end else if (cnt_r < CW'(ffa_pkg::TABLE_ENTRIES) && pos_r == cnt_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_r);
          mem_wdata = '{start: addr_r, len: size_r};
        end
      end
      S_SHDN: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r - 1'b1);
        mem_wdata = mem_q;
      end
      S_SHUP: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r + 1'b1);
        mem_wdata = mem_q;
      end
      S_WINS: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        mem_wdata = '{start: addr_r, len: size_r};
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      peak_r      <= '0;
      sum_r       <= '0;
      lostc_r     <= '0;
      lostb_r     <= '0;
      out_valid_r <= 1'b0;
      have_prev_r <= 1'b0;
      next_vld_r  <= 1'b0;
    end else begin
      // In S_RESP the response register is handled by that state alone.
      if (out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r       <= in_req_type;
            addr_r      <= in_block_addr;
            size_r      <= in_block_size;
            have_prev_r <= 1'b0;
            next_vld_r  <= 1'b0;
            chk_r       <= '0;
            grant_r     <= '0;
            status_r    <= ffa_pkg::ST_OK;
            if (cnt_r == '0) begin
              if (in_req_type == ffa_pkg::REQ_ALLOC) begin
                status_r <= ffa_pkg::ST_NO_SPACE;
                state_r  <= S_RESP;
              end else begin
                pos_r   <= '0;
                state_r <= S_FDEC;
              end
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (req_r == ffa_pkg::REQ_ALLOC) begin
            if (fits) begin
              grant_r <= mem_q.start;
              sum_r   <= sum_r - size_r;
              if (mem_q.len == size_r) begin
                // The region is used up: close the gap behind it.
                cnt_r <= cnt_r - 1'b1;
                lim_r <= cnt_r;
                idx_r <= chk_r + 1'b1;
                state_r <= last_chk ? S_RESP : S_SHDN;
              end else begin
                state_r <= S_RESP;
              end
            end else if (last_chk) begin
              status_r <= ffa_pkg::ST_NO_SPACE;
              state_r  <= S_RESP;
            end else begin
              chk_r <= chk_r + 1'b1;
            end
          end else begin
            if (mem_q.start > addr_r) begin
              pos_r      <= chk_r;
              next_vld_r <= 1'b1;
              next_r     <= mem_q;
              state_r    <= S_FDEC;
            end else begin
              prev_r      <= mem_q;
              have_prev_r <= 1'b1;
              if (last_chk) begin
                pos_r   <= cnt_r;
                state_r <= S_FDEC;
              end else begin
                chk_r <= chk_r + 1'b1;
              end
            end
          end
        end
        S_FDEC: begin
          if (prev_adj) begin
            sum_r <= sum_r + size_r;
            if (next_adj) begin
              cnt_r   <= cnt_r - 1'b1;
              lim_r   <= cnt_r;
              idx_r   <= pos_r + 1'b1;
              state_r <= ((pos_r + 1'b1) == cnt_r) ? S_RESP : S_SHDN;
            end else begin
              state_r <= S_RESP;
            end
          end else if (next_adj) begin
            sum_r   <= sum_r + size_r;
            state_r <= S_RESP;
          end else if (cnt_r < CW'(ffa_pkg::TABLE_ENTRIES)) begin
            sum_r <= sum_r + size_r;
            cnt_r <= cnt_r + 1'b1;
            if (peak_r < cnt_r + 1'b1) begin
              peak_r <= cnt_r + 1'b1;
            end
            idx_r   <= cnt_r - 1'b1;
            state_r <= (pos_r == cnt_r) ? S_RESP : S_SHUP;
          end else begin
            lostc_r  <= lostc_r + 32'd1;
            lostb_r  <= lostb_r + size_r;
            status_r <= ffa_pkg::ST_LOST;
            state_r  <= S_RESP;
          end
        end
        S_SHDN: begin
          if ((idx_r + 1'b1) == lim_r) begin
            state_r <= S_RESP;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SHUP: begin
          if (idx_r == pos_r) begin
            state_r <= S_WINS;
          end else begin
            idx_r <= idx_r - 1'b1;
          end
        end
        S_WINS: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r      <= 1'b1;
            out_granted_addr <= grant_r;
            out_status       <= status_r;
            out_free_total   <= sum_r;
            out_entry_count  <= cnt_r;
            out_peak_entries <= peak_r;
            out_lost_count   <= lostc_r;
            out_lost_bytes   <= lostb_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ffa_pkg::TABLE_ENTRIES))
    else $error("entry count above table size");

  a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= cnt_r)
    else $error("peak below current entry count");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + 1'b1 || cnt_r == $past(cnt_r) - 1'b1))
    else $error("entry count jumped");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !mem_we)
    else $error("table written outside a request");
`endif

endmodule

`default_nettype wire

### rtl/ffa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
